// File: rtl/tzoc_pkg.sv
package tzoc_pkg;

    localparam int MAX_TRANSITIONS = 64;
    localparam int IDX_W = $clog2(MAX_TRANSITIONS);
    localparam int ADDR_W = IDX_W + 1;
    localparam int CNT_W = 7;
    localparam int ENTRY_W = 27;
    localparam int TIME_W = 48;
    localparam int WIDE_W = 50;
    localparam int OFF_W = 12;
    localparam int DAYS_W = 22;

    localparam int SEC_PER_DAY = 86400;
    localparam int SEC_PER_MIN = 60;
    localparam int EPOCH_YEAR = 1970;
    localparam int EPOCH_PREV = 1969;
    localparam int DAYS_PER_YEAR = 365;
    localparam int RECIP_100 = 5243;
    localparam int RECIP_SHIFT = 19;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TO_LOCAL = 2'd1,
        OP_CONVERT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_BASE0  = 3'd0,
        CFG_BASE1  = 3'd1,
        CFG_DST0   = 3'd2,
        CFG_DST1   = 3'd3,
        CFG_COUNT0 = 3'd4,
        CFG_COUNT1 = 3'd5,
        CFG_YEAR   = 3'd6,
        CFG_SPARE  = 3'd7
    } cfg_idx_t;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_PREP1 = 10'b0000000010,
        ST_PREP2 = 10'b0000000100,
        ST_WSTART = 10'b0000001000,
        ST_WRD   = 10'b0000010000,
        ST_WACC  = 10'b0000100000,
        ST_WMUL  = 10'b0001000000,
        ST_WCMP  = 10'b0010000000,
        ST_WDONE = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    typedef enum logic [4:0] {
        PH_IT1    = 5'b00001,
        PH_IT2    = 5'b00010,
        PH_BEFORE = 5'b00100,
        PH_AFTER  = 5'b01000,
        PH_FINAL  = 5'b10000
    } phase_t;

    // Days from 1 January 1970 to 1 January of the given year, proleptic Gregorian.
    function automatic logic signed [DAYS_W-1:0] days_until_year(input logic [11:0] year);
        logic signed [13:0] y;
        logic signed [13:0] q4;
        logic signed [13:0] q100;
        logic signed [13:0] q400;
        logic [25:0] p100;
        logic [25:0] p400;
        logic signed [DAYS_W-1:0] d;
        y = 14'(signed'({2'b00, year})) - 14'sd1;
        p100 = 26'(year - 12'd1) * 26'(RECIP_100);
        q4 = y >>> 2;
        p400 = 26'(q4[11:0]) * 26'(RECIP_100);
        if (year == 12'd0) begin
            q100 = -14'sd1;
            q400 = -14'sd1;
        end
        else begin
            q100 = 14'(p100 >> RECIP_SHIFT);
            q400 = 14'(p400 >> RECIP_SHIFT);
        end
        d = DAYS_W'(y - 14'(EPOCH_PREV)) * DAYS_W'(DAYS_PER_YEAR)
          + DAYS_W'(q4 - 14'(EPOCH_PREV / 4))
          - DAYS_W'(q100 - 14'(EPOCH_PREV / 100))
          + DAYS_W'(q400 - 14'(EPOCH_PREV / 400));
        return d;
    endfunction

endpackage

// File: rtl/timezone_offset_converter_core.sv
// Channel | Direction | Contents
// s_*     | in        | tuser: operation, zone; tdata: index, day delta, minute, time
// m_*     | out       | tuser: status; tdata: result time, offset minutes
// cfg_*   | in        | register index and write data, always ready
// Loads and ignored operations go from IDLE through PREP1 and OUT back to IDLE. A query
// walks the zone's table through WRD, WACC, WMUL and WCMP for each entry read from the
// single table memory: a UTC-to-local request makes one walk and a convert request up to
// five walks. Reset is asynchronous
// and clears control state; the table holds nothing until loaded. One request is
// in work at a time; a result waiting in the output register holds the next one.
module timezone_offset_converter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // operation [1:0], zone [2]
    input  logic [87:0] s_tdata,   // entry_index, day_delta, minute_of_day, time_value, zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // status
    output logic [63:0] m_tdata,   // result_time, offset_minutes, zeros
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int TW = tzoc_pkg::WIDE_W;

    logic [tzoc_pkg::ENTRY_W-1:0] mem [2**tzoc_pkg::ADDR_W];
    logic [tzoc_pkg::ENTRY_W-1:0] rdata_reg;
    logic                         mem_we;
    logic [tzoc_pkg::ADDR_W-1:0]  mem_waddr;
    logic [tzoc_pkg::ADDR_W-1:0]  mem_raddr;

    logic signed [10:0] base0_reg, base1_reg;
    logic signed [8:0]  dst0_reg, dst1_reg;
    logic [6:0]         count0_reg, count1_reg;
    logic [11:0]        year_reg;

    tzoc_pkg::state_t state_reg;
    tzoc_pkg::phase_t phase_reg;
    tzoc_pkg::op_t    op_reg;
    logic             zone_reg;
    logic             walk_zone_reg;
    logic [tzoc_pkg::CNT_W-1:0] i_reg;
    logic signed [tzoc_pkg::DAYS_W-1:0] days_reg;
    logic signed [TW-1:0] start_reg;
    logic [TW-1:0]        day_sec_reg;
    logic [10:0]          mod_reg;
    logic signed [TW-1:0] when_reg;
    logic signed [TW-1:0] local_reg;
    logic signed [TW-1:0] utc_reg;
    logic signed [TW-1:0] walk_utc_reg;
    logic signed [tzoc_pkg::OFF_W-1:0] off_reg;
    logic signed [tzoc_pkg::OFF_W-1:0] before_reg;
    logic                 status_reg;

    logic                 out_valid_reg;
    logic [47:0]          out_time_reg;
    logic [10:0]          out_off_reg;
    logic                 out_status_reg;

    logic signed [TW-1:0] res_time;
    logic signed [tzoc_pkg::OFF_W-1:0] off_out;

    logic signed [10:0] w_base;
    logic signed [8:0]  w_dst;
    logic [6:0]         w_cnt_raw;
    logic [tzoc_pkg::CNT_W-1:0] w_cnt;
    logic signed [TW-1:0] off_sec;
    logic signed [TW-1:0] guess;
    logic signed [tzoc_pkg::OFF_W-1:0] max_off;
    logic signed [TW-1:0] max_sec;
    logic               s_acc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == tzoc_pkg::ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'd0, out_off_reg, out_time_reg};

    assign w_base    = walk_zone_reg ? base1_reg : base0_reg;
    assign w_dst     = walk_zone_reg ? dst1_reg : dst0_reg;
    assign w_cnt_raw = walk_zone_reg ? count1_reg : count0_reg;
    assign w_cnt     = (w_cnt_raw > 7'(tzoc_pkg::MAX_TRANSITIONS))
                     ? 7'(tzoc_pkg::MAX_TRANSITIONS) : w_cnt_raw;

    assign off_sec = TW'(off_reg) * TW'(tzoc_pkg::SEC_PER_MIN);
    assign guess   = local_reg - off_sec;
    assign max_off = (before_reg > off_reg) ? before_reg : off_reg;
    assign max_sec = TW'(max_off) * TW'(tzoc_pkg::SEC_PER_MIN);
    assign res_time = utc_reg + off_sec;
    assign off_out  = off_reg;

    assign mem_we    = s_acc && (tzoc_pkg::op_t'(s_tuser[1:0]) == tzoc_pkg::OP_LOAD)
                     && ({1'b0, s_tdata[5:0]} < 7'(tzoc_pkg::MAX_TRANSITIONS));
    assign mem_waddr = {s_tuser[2], s_tdata[tzoc_pkg::IDX_W-1:0]};
    assign mem_raddr = {walk_zone_reg, i_reg[tzoc_pkg::IDX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= {s_tdata[21:6], s_tdata[32:22]};
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base0_reg  <= '0;
            base1_reg  <= '0;
            dst0_reg   <= '0;
            dst1_reg   <= '0;
            count0_reg <= '0;
            count1_reg <= '0;
            year_reg   <= 12'(tzoc_pkg::EPOCH_YEAR + 54);
        end
        else if (cfg_valid)
        begin
            unique case (tzoc_pkg::cfg_idx_t'(cfg_index))
                tzoc_pkg::CFG_BASE0:  base0_reg  <= cfg_data[10:0];
                tzoc_pkg::CFG_BASE1:  base1_reg  <= cfg_data[10:0];
                tzoc_pkg::CFG_DST0:   dst0_reg   <= cfg_data[8:0];
                tzoc_pkg::CFG_DST1:   dst1_reg   <= cfg_data[8:0];
                tzoc_pkg::CFG_COUNT0: count0_reg <= cfg_data[6:0];
                tzoc_pkg::CFG_COUNT1: count1_reg <= cfg_data[6:0];
                tzoc_pkg::CFG_YEAR:   year_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tzoc_pkg::ST_IDLE;
            phase_reg      <= tzoc_pkg::PH_FINAL;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                tzoc_pkg::ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        op_reg        <= tzoc_pkg::op_t'(s_tuser[1:0]);
                        zone_reg      <= s_tuser[2];
                        walk_zone_reg <= s_tuser[2];
                        local_reg     <= TW'(signed'(s_tdata[80:33]));
                        status_reg    <= ({1'b0, s_tdata[5:0]}
                                          >= 7'(tzoc_pkg::MAX_TRANSITIONS));
                        utc_reg       <= '0;
                        off_reg       <= '0;
                        state_reg     <= tzoc_pkg::ST_PREP1;
                    end
                end
                tzoc_pkg::ST_PREP1:
                begin
                    days_reg <= tzoc_pkg::days_until_year(year_reg);
                    if (op_reg == tzoc_pkg::OP_TO_LOCAL)
                    begin
                        phase_reg <= tzoc_pkg::PH_FINAL;
                        utc_reg   <= local_reg;
                        state_reg <= tzoc_pkg::ST_PREP2;
                    end
                    else if (op_reg == tzoc_pkg::OP_CONVERT)
                    begin
                        phase_reg <= tzoc_pkg::PH_IT1;
                        utc_reg   <= local_reg - TW'(w_base) * TW'(tzoc_pkg::SEC_PER_MIN);
                        state_reg <= tzoc_pkg::ST_PREP2;
                    end
                    else
                    begin
                        if (op_reg == tzoc_pkg::OP_NONE)
                        begin
                            status_reg <= 1'b0;
                        end
                        state_reg <= tzoc_pkg::ST_OUT;
                    end
                end
                tzoc_pkg::ST_PREP2:
                begin
                    start_reg    <= TW'(days_reg) * TW'(tzoc_pkg::SEC_PER_DAY);
                    walk_utc_reg <= utc_reg;
                    state_reg    <= tzoc_pkg::ST_WSTART;
                end
                tzoc_pkg::ST_WSTART:
                begin
                    off_reg     <= tzoc_pkg::OFF_W'(w_base);
                    i_reg       <= '0;
                    day_sec_reg <= '0;
                    state_reg   <= (w_cnt == '0) ? tzoc_pkg::ST_WDONE : tzoc_pkg::ST_WRD;
                end
                tzoc_pkg::ST_WRD:
                begin
                    state_reg <= tzoc_pkg::ST_WACC;
                end
                tzoc_pkg::ST_WACC:
                begin
                    day_sec_reg <= day_sec_reg + TW'(rdata_reg[26:11]) * TW'(tzoc_pkg::SEC_PER_DAY);
                    mod_reg     <= rdata_reg[10:0];
                    state_reg   <= tzoc_pkg::ST_WMUL;
                end
                tzoc_pkg::ST_WMUL:
                begin
                    when_reg  <= start_reg + signed'(day_sec_reg)
                               + TW'(mod_reg) * TW'(tzoc_pkg::SEC_PER_MIN);
                    state_reg <= tzoc_pkg::ST_WCMP;
                end
                tzoc_pkg::ST_WCMP:
                begin
                    if (walk_utc_reg >= when_reg)
                    begin
                        off_reg <= tzoc_pkg::OFF_W'(w_base)
                                 + (i_reg[0] ? '0 : tzoc_pkg::OFF_W'(w_dst));
                        if (i_reg + 7'd1 == w_cnt)
                        begin
                            state_reg <= tzoc_pkg::ST_WDONE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 7'd1;
                            state_reg <= tzoc_pkg::ST_WRD;
                        end
                    end
                    else
                    begin
                        state_reg <= tzoc_pkg::ST_WDONE;
                    end
                end
                tzoc_pkg::ST_WDONE:
                begin
                    state_reg <= tzoc_pkg::ST_WSTART;
                    unique case (phase_reg)
                        tzoc_pkg::PH_IT1:
                        begin
                            utc_reg <= guess;
                            if (guess == utc_reg)
                            begin
                                phase_reg    <= tzoc_pkg::PH_BEFORE;
                                walk_utc_reg <= guess - TW'(tzoc_pkg::SEC_PER_MIN);
                            end
                            else
                            begin
                                phase_reg    <= tzoc_pkg::PH_IT2;
                                walk_utc_reg <= guess;
                            end
                        end
                        tzoc_pkg::PH_IT2:
                        begin
                            utc_reg      <= guess;
                            phase_reg    <= tzoc_pkg::PH_BEFORE;
                            walk_utc_reg <= guess - TW'(tzoc_pkg::SEC_PER_MIN);
                        end
                        tzoc_pkg::PH_BEFORE:
                        begin
                            before_reg   <= off_reg;
                            phase_reg    <= tzoc_pkg::PH_AFTER;
                            walk_utc_reg <= utc_reg + TW'(tzoc_pkg::SEC_PER_MIN);
                        end
                        tzoc_pkg::PH_AFTER:
                        begin
                            phase_reg     <= tzoc_pkg::PH_FINAL;
                            walk_zone_reg <= ~zone_reg;
                            if (before_reg != off_reg)
                            begin
                                utc_reg      <= local_reg - max_sec;
                                walk_utc_reg <= local_reg - max_sec;
                            end
                            else
                            begin
                                walk_utc_reg <= utc_reg;
                            end
                        end
                        tzoc_pkg::PH_FINAL:
                        begin
                            state_reg <= tzoc_pkg::ST_OUT;
                        end
                        default: state_reg <= tzoc_pkg::ST_OUT;
                    endcase
                end
                tzoc_pkg::ST_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= status_reg;
                        if (op_reg == tzoc_pkg::OP_TO_LOCAL || op_reg == tzoc_pkg::OP_CONVERT)
                        begin
                            out_time_reg <= res_time[47:0];
                            out_off_reg  <= off_out[10:0];
                        end
                        else
                        begin
                            out_time_reg <= '0;
                            out_off_reg  <= '0;
                        end
                        state_reg <= tzoc_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= tzoc_pkg::ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tzoc_pkg::ST_WCMP) |-> (i_reg < w_cnt))
        else $error("table walk index beyond the transition count");

    a_load_short: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && tzoc_pkg::op_t'(s_tuser[1:0]) == tzoc_pkg::OP_LOAD)
        |=> (state_reg == tzoc_pkg::ST_PREP1))
        else $error("load request did not advance");

    a_out_only_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == tzoc_pkg::ST_OUT))
        else $error("result raised outside the output state");
`endif

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

typedef struct {
    logic [47:0] result_time;
    logic [10:0] offset_minutes;
    logic        status;
} tz_result_t;

class tz_scoreboard;
    logic signed [10:0] base_off [2];
    logic signed [8:0]  dst_off [2];
    logic [6:0]         trans_cnt [2];
    logic [11:0]        gen_year;
    logic [26:0]        trans_tbl [128];
    tz_result_t         expected_q [$];
    int                 failures;
    int                 accepted;

    function new();
        base_off = '{0, 0};
        dst_off = '{0, 0};
        trans_cnt = '{0, 0};
        gen_year = 12'd2024;
        failures = 0;
        accepted = 0;
    endfunction

    function void write_reg(tzoc_pkg::cfg_idx_t idx, logic [11:0] value);
        case (idx)
            tzoc_pkg::CFG_BASE0:  base_off[0] = value[10:0];
            tzoc_pkg::CFG_BASE1:  base_off[1] = value[10:0];
            tzoc_pkg::CFG_DST0:   dst_off[0] = value[8:0];
            tzoc_pkg::CFG_DST1:   dst_off[1] = value[8:0];
            tzoc_pkg::CFG_COUNT0: trans_cnt[0] = value[6:0];
            tzoc_pkg::CFG_COUNT1: trans_cnt[1] = value[6:0];
            tzoc_pkg::CFG_YEAR:   gen_year = value;
            default: ;
        endcase
    endfunction

    function longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    function longint year_start_sec();
        longint y;
        longint leaps;
        y = longint'(gen_year) - 1;
        leaps = (floor_div(y, 4) - floor_div(1969, 4))
              - (floor_div(y, 100) - floor_div(1969, 100))
              + (floor_div(y, 400) - floor_div(1969, 400));
        return ((y - 1969) * 365 + leaps) * 86400;
    endfunction

    function longint transition_instant(int z, int n);
        longint acc;
        acc = 0;
        for (int i = 0; i <= n; i++)
            acc += longint'(trans_tbl[z * 64 + i][26:11]);
        return year_start_sec() + acc * 86400 + longint'(trans_tbl[z * 64 + n][10:0]) * 60;
    endfunction

    function longint zone_offset(int z, longint utc);
        longint base;
        longint off;
        longint acc;
        longint start;
        int     cnt;
        base = base_off[z];
        off = base;
        acc = 0;
        start = year_start_sec();
        cnt = trans_cnt[z] > 64 ? 64 : trans_cnt[z];
        for (int i = 0; i < cnt; i++)
        begin
            acc += longint'(trans_tbl[z * 64 + i][26:11]);
            if (utc >= start + acc * 86400 + longint'(trans_tbl[z * 64 + i][10:0]) * 60)
                off = base + ((i % 2 == 0) ? longint'(dst_off[z]) : 0);
            else
                break;
        end
        return off;
    endfunction

    function longint resolve_utc(int z, longint local_t);
        longint utc;
        longint guess;
        longint off_pre;
        longint off_post;
        utc = local_t - longint'(base_off[z]) * 60;
        for (int k = 0; k < 2; k++)
        begin
            guess = local_t - zone_offset(z, utc) * 60;
            if (guess == utc)
                break;
            utc = guess;
        end
        off_pre = zone_offset(z, utc - 60);
        off_post = zone_offset(z, utc + 60);
        if (off_pre != off_post)
            utc = local_t - (off_pre > off_post ? off_pre : off_post) * 60;
        return utc;
    endfunction

    function void note_request(tzoc_pkg::op_t op, logic z, logic [5:0] idx, logic [15:0] dd,
                               logic [10:0] mod, logic [47:0] tv);
        tz_result_t r;
        longint t;
        longint res;
        longint off;
        t = longint'(signed'(tv));
        res = 0;
        off = 0;
        r.status = 1'b0;
        case (op)
            tzoc_pkg::OP_LOAD:     trans_tbl[z * 64 + idx] = {dd, mod};
            tzoc_pkg::OP_TO_LOCAL:
            begin
                off = zone_offset(z, t);
                res = t + off * 60;
            end
            tzoc_pkg::OP_CONVERT:
            begin
                t = resolve_utc(z, t);
                off = zone_offset(!z, t);
                res = t + off * 60;
            end
            default: ;
        endcase
        r.result_time = res[47:0];
        r.offset_minutes = off[10:0];
        expected_q.push_back(r);
        accepted++;
    endfunction

    function void check_result(logic [47:0] rt, logic [10:0] om, logic st);
        tz_result_t e;
        if (expected_q.size() == 0)
        begin
            $error("result with nothing expected: result_time %0h", rt);
            failures++;
            return;
        end
        e = expected_q.pop_front();
        if (rt !== e.result_time)
        begin
            $error("result_time: expected %0h, got %0h", e.result_time, rt);
            failures++;
        end
        if (om !== e.offset_minutes)
        begin
            $error("offset_minutes: expected %0h, got %0h", e.offset_minutes, om);
            failures++;
        end
        if (st !== e.status)
        begin
            $error("status: expected %0b, got %0b", e.status, st);
            failures++;
        end
    endfunction
endclass

module tb;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tuser;
    logic [63:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    tz_scoreboard sb;
    bit           quiet;

    timezone_offset_converter_core u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL timezone_offset_converter_core");
        $finish;
    end

    // The receiver stalls in bursts, and once holds off for a long stretch so that
    // the block backs up and refuses further requests.
    initial
    begin : receiver
        int stall_left;
        bit held;
        stall_left = 0;
        held = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[47:0], m_tdata[58:48], m_tuser);
            if (!held && !quiet && sb.accepted >= 300)
            begin
                held = 1;
                stall_left = 3000;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic send_request(tzoc_pkg::op_t op, logic z, logic [5:0] idx, logic [15:0] dd,
                                logic [10:0] mod, logic [47:0] tv);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {z, op};
        s_tdata <= {7'd0, tv, mod, dd, idx};
        do @(posedge clk); while (!s_tready);
        sb.note_request(op, z, idx, dd, mod, tv);
    endtask

    task automatic write_reg(tzoc_pkg::cfg_idx_t idx, logic [11:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, value);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_regs(int b0, int b1, int d0, int d1, int c0, int c1, int yr);
        drain();
        write_reg(tzoc_pkg::CFG_BASE0, 12'(b0));
        write_reg(tzoc_pkg::CFG_BASE1, 12'(b1));
        write_reg(tzoc_pkg::CFG_DST0, 12'(d0));
        write_reg(tzoc_pkg::CFG_DST1, 12'(d1));
        write_reg(tzoc_pkg::CFG_COUNT0, 12'(c0));
        write_reg(tzoc_pkg::CFG_COUNT1, 12'(c1));
        write_reg(tzoc_pkg::CFG_YEAR, 12'(yr));
        cfg_valid <= 1'b0;
    endtask

    task automatic load_entry(logic z, int idx);
        logic [15:0] dd;
        logic [10:0] mod;
        case ($urandom_range(0, 9))
            0: dd = 16'hFFFF;
            1: dd = 16'd0;
            default: dd = 16'($urandom_range(0, 200));
        endcase
        mod = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1439));
        send_request(tzoc_pkg::OP_LOAD, z, 6'(idx), dd, mod, 48'({$urandom, $urandom}));
    endtask

    function automatic logic [47:0] pick_time(logic z);
        longint t;
        int     n;
        int     cnt;
        cnt = sb.trans_cnt[z] > 64 ? 64 : sb.trans_cnt[z];
        case ($urandom_range(0, 9))
            0: return 48'({$urandom, $urandom});
            1, 2: t = sb.year_start_sec() + longint'($urandom_range(0, 500)) * 86400
                    + $urandom_range(0, 86399);
            default:
            begin
                n = (cnt == 0) ? 0 : $urandom_range(0, cnt - 1);
                t = sb.transition_instant(z, n) + longint'(sb.base_off[z]) * 60
                  + $signed($urandom_range(0, 21600)) - 10800;
            end
        endcase
        return t[47:0];
    endfunction

    task automatic random_requests(int n);
        logic z;
        for (int i = 0; i < n; i++)
        begin
            z = 1'($urandom);
            case ($urandom_range(0, 19))
                0, 1, 2: load_entry(z, $urandom_range(0, 63));
                3: send_request(tzoc_pkg::OP_NONE, z, 6'($urandom), 16'($urandom),
                                11'($urandom), 48'({$urandom, $urandom}));
                4, 5, 6, 7, 8, 9, 10, 11:
                    send_request(tzoc_pkg::OP_TO_LOCAL, z, 6'($urandom), 16'($urandom),
                                 11'($urandom), pick_time(z));
                default:
                    send_request(tzoc_pkg::OP_CONVERT, z, 6'($urandom), 16'($urandom),
                                 11'($urandom), pick_time(z));
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        quiet = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int z = 0; z < 2; z++)
            for (int i = 0; i < 64; i++)
                load_entry(1'(z), i);

        send_request(tzoc_pkg::OP_TO_LOCAL, 1'b0, 6'd0, 16'd0, 11'd0, 48'd0);
        send_request(tzoc_pkg::OP_CONVERT, 1'b1, 6'd0, 16'd0, 11'd0, 48'd0);
        set_regs(60, -300, 60, 60, 4, 4, 2024);
        send_request(tzoc_pkg::OP_TO_LOCAL, 1'b0, 6'd0, 16'd0, 11'd0, 48'h7FFF_FFFF_FFFF);
        send_request(tzoc_pkg::OP_TO_LOCAL, 1'b1, 6'h3F, 16'hFFFF, 11'h7FF,
                     48'h8000_0000_0000);
        send_request(tzoc_pkg::OP_CONVERT, 1'b0, 6'd0, 16'd0, 11'd0, 48'h7FFF_FFFF_FFFF);
        send_request(tzoc_pkg::OP_CONVERT, 1'b1, 6'd0, 16'd0, 11'd0, 48'h8000_0000_0000);
        send_request(tzoc_pkg::OP_NONE, 1'b1, 6'h3F, 16'hFFFF, 11'h7FF, 48'hFFFF_FFFF_FFFF);
        for (int z = 0; z < 2; z++)
            for (int n = 0; n < 2; n++)
                for (int d = -1; d <= 1; d++)
                    send_request(tzoc_pkg::OP_CONVERT, 1'(z), 6'd0, 16'd0, 11'd0,
                                 48'(sb.transition_instant(z, n)
                                     + longint'(sb.base_off[z]) * 60 + d * 1800));
        send_request(tzoc_pkg::OP_LOAD, 1'b1, 6'h3F, 16'hFFFF, 11'h7FF, 48'd0);
        send_request(tzoc_pkg::OP_LOAD, 1'b1, 6'h3F, 16'd0, 11'd0, 48'd0);

        set_regs(840, -720, 180, -180, 64, 64, 2200);
        random_requests(25);
        set_regs(-720, 840, -180, 180, 0, 0, 1970);
        random_requests(60);
        set_regs(1023, -1024, 255, -256, 127, 100, 4095);
        random_requests(20);
        set_regs($urandom_range(0, 1560) - 720, $urandom_range(0, 1560) - 720,
                 -60, 120, 3, 5, 0);
        random_requests(40);
        for (int p = 0; p < 6; p++)
        begin
            set_regs($urandom_range(0, 1560) - 720, $urandom_range(0, 1560) - 720,
                     $urandom_range(0, 360) - 180, $urandom_range(0, 360) - 180,
                     $urandom_range(0, 8), $urandom_range(0, 8),
                     $urandom_range(1970, 2200));
            if (p == 5)
                quiet = 1;
            random_requests(160);
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.failures == 0 && sb.expected_q.size() == 0)
            $display("PASS timezone_offset_converter_core");
        else
            $display("FAIL timezone_offset_converter_core");
        $finish;
    end
endmodule

// File: timezone_offset_converter_core.f
rtl/tzoc_pkg.sv
rtl/timezone_offset_converter_core.sv
verif/tb.sv
